### src/assert_macros.svh
// Assertion macros used by the top level of the positional list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define PLE_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define PLE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/ple_pkg.sv
// Package with types, codes and constants of the positional list engine.
package ple_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int POS_W        = 8;
    localparam int COUNT_W      = 7;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_DUMP   = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_DRAIN,
        S_INS_PUT,
        S_DEL_SCAN,
        S_DEL_DRAIN,
        S_DUMP_SCAN,
        S_DUMP_DRAIN
    } state_t;

    // One result beat as produced by the sequencer.
    typedef struct packed {
        logic                      valid;
        logic signed [DATA_W-1:0]  value;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } result_t;

endpackage

### src/ple_mem.sv
// Entry store: one write port and one registered read port.
module ple_mem #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(ple_pkg::CAPACITY_DEF)
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [ple_pkg::DATA_W-1:0]    wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [ple_pkg::DATA_W-1:0]    rdata
);

    logic [ple_pkg::DATA_W-1:0] mem [DEPTH];
    logic [ple_pkg::DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ple_seq.sv
// Sequencer: walks the entry store with one shared index unit to shift, fetch and dump.
module ple_seq #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [1:0]                          req_type,
    input  logic [ple_pkg::POS_W-1:0]           position,
    input  logic signed [ple_pkg::DATA_W-1:0]   value,
    output logic                                busy,
    output ple_pkg::result_t                    result
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int OCW = ple_pkg::COUNT_W;
    localparam int DW  = ple_pkg::DATA_W;

    ple_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   lim_reg, lim_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic            pend_reg, pend_next;
    logic            cap_reg, cap_next;
    logic            first_reg, first_next;
    logic            emit_reg, emit_next;
    logic            elast_reg, elast_next;
    logic [DW-1:0]   val_reg, val_next;
    logic [DW-1:0]   removed_reg, removed_next;
    logic [CW-1:0]   count_reg, count_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [DW-1:0]   mem_wdata;
    logic            mem_re;
    logic [DW-1:0]   mem_rdata;

    logic [8:0]      pos9;
    logic [8:0]      n9;
    logic            is_full;
    logic            is_empty;
    logic            ins_bad;
    logic            del_bad;
    logic            ins_at_end;
    logic            step_up;
    logic [AW-1:0]   idx_step;
    logic            at_lim;
    logic [CW-1:0]   cnt_inc;
    logic [CW-1:0]   cnt_dec;

    // Request decode against the current count
    assign pos9       = {1'b0, position};
    assign n9         = 9'(count_reg);
    assign is_full    = (n9 >= 9'(CAPACITY));
    assign is_empty   = (count_reg == '0);
    assign ins_bad    = (position == '0) || (pos9 > (n9 + 9'd1));
    assign del_bad    = (position == '0) || (pos9 > n9);
    assign ins_at_end = (pos9 == (n9 + 9'd1));
    assign cnt_inc    = count_reg + 1'b1;
    assign cnt_dec    = count_reg - 1'b1;

    // Shared index unit: one step and one limit compare per cycle
    assign step_up  = (state_reg != ple_pkg::S_INS_SHIFT);
    assign idx_step = step_up ? (idx_reg + 1'b1) : (idx_reg - 1'b1);
    assign at_lim   = (idx_reg == lim_reg);

    assign busy = (state_reg != ple_pkg::S_IDLE);

    ple_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        ple_pkg::REQ_INSERT:
                        begin
                            if (!is_full && !ins_bad)
                            begin
                                state_next = ins_at_end ? ple_pkg::S_INS_PUT
                                                        : ple_pkg::S_INS_SHIFT;
                            end
                        end
                        ple_pkg::REQ_DELETE:
                        begin
                            if (!is_empty && !del_bad)
                            begin
                                state_next = ple_pkg::S_DEL_SCAN;
                            end
                        end
                        ple_pkg::REQ_DUMP:
                        begin
                            if (!is_empty)
                            begin
                                state_next = ple_pkg::S_DUMP_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ple_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ple_pkg::S_INS_SHIFT:
            begin
                if (at_lim)
                begin
                    state_next = ple_pkg::S_INS_DRAIN;
                end
            end
            ple_pkg::S_INS_DRAIN:  state_next = ple_pkg::S_INS_PUT;
            ple_pkg::S_INS_PUT:    state_next = ple_pkg::S_IDLE;
            ple_pkg::S_DEL_SCAN:
            begin
                if (at_lim)
                begin
                    state_next = ple_pkg::S_DEL_DRAIN;
                end
            end
            ple_pkg::S_DEL_DRAIN:  state_next = ple_pkg::S_IDLE;
            ple_pkg::S_DUMP_SCAN:
            begin
                if (at_lim)
                begin
                    state_next = ple_pkg::S_DUMP_DRAIN;
                end
            end
            ple_pkg::S_DUMP_DRAIN: state_next = ple_pkg::S_IDLE;
            default:               state_next = ple_pkg::S_IDLE;
        endcase
    end

    // Datapath, store control and result beat
    always_comb
    begin
        idx_next     = idx_reg;
        lim_next     = lim_reg;
        wr_addr_next = wr_addr_reg;
        pend_next    = 1'b0;
        cap_next     = 1'b0;
        first_next   = first_reg;
        emit_next    = 1'b0;
        elast_next   = elast_reg;
        val_next     = val_reg;
        removed_next = cap_reg ? mem_rdata : removed_reg;
        count_next   = count_reg;

        // a pending shift write lands in the cycle after its read
        mem_we    = pend_reg;
        mem_waddr = wr_addr_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;

        result        = '0;
        result.status = ple_pkg::ST_OK;
        result.count  = OCW'(count_reg);

        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (start)
                begin
                    val_next = value;
                    case (req_type)
                        ple_pkg::REQ_INSERT:
                        begin
                            if (is_full)
                            begin
                                result.valid  = 1'b1;
                                result.status = ple_pkg::ST_FULL;
                                result.last   = 1'b1;
                            end
                            else if (ins_bad)
                            begin
                                result.valid  = 1'b1;
                                result.status = ple_pkg::ST_BADPOS;
                                result.last   = 1'b1;
                            end
                            else
                            begin
                                idx_next = AW'(n9 - 9'd1);
                                lim_next = AW'(pos9 - 9'd1);
                            end
                        end
                        ple_pkg::REQ_DELETE:
                        begin
                            if (is_empty)
                            begin
                                result.valid  = 1'b1;
                                result.status = ple_pkg::ST_EMPTY;
                                result.last   = 1'b1;
                            end
                            else if (del_bad)
                            begin
                                result.valid  = 1'b1;
                                result.status = ple_pkg::ST_BADPOS;
                                result.last   = 1'b1;
                            end
                            else
                            begin
                                idx_next   = AW'(pos9 - 9'd1);
                                lim_next   = AW'(n9 - 9'd1);
                                first_next = 1'b1;
                            end
                        end
                        ple_pkg::REQ_DUMP:
                        begin
                            if (is_empty)
                            begin
                                result.valid  = 1'b1;
                                result.status = ple_pkg::ST_EMPTY;
                                result.last   = 1'b1;
                            end
                            else
                            begin
                                idx_next = '0;
                                lim_next = AW'(n9 - 9'd1);
                            end
                        end
                        default:
                        begin
                            result.valid  = 1'b1;
                            result.status = ple_pkg::ST_BADPOS;
                            result.last   = 1'b1;
                        end
                    endcase
                end
            end
            // move entries up one place, top first
            ple_pkg::S_INS_SHIFT:
            begin
                mem_re       = 1'b1;
                pend_next    = 1'b1;
                wr_addr_next = idx_reg + 1'b1;
                if (!at_lim)
                begin
                    idx_next = idx_step;
                end
            end
            ple_pkg::S_INS_DRAIN:
            begin
                pend_next = 1'b0;
            end
            ple_pkg::S_INS_PUT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = lim_reg;
                mem_wdata     = val_reg;
                count_next    = cnt_inc;
                result.valid  = 1'b1;
                result.count  = OCW'(cnt_inc);
                result.last   = 1'b1;
            end
            // first read fetches the removed entry, the rest move down one place
            ple_pkg::S_DEL_SCAN:
            begin
                mem_re       = 1'b1;
                first_next   = 1'b0;
                cap_next     = first_reg;
                pend_next    = !first_reg;
                wr_addr_next = idx_reg - 1'b1;
                if (!at_lim)
                begin
                    idx_next = idx_step;
                end
            end
            ple_pkg::S_DEL_DRAIN:
            begin
                count_next   = cnt_dec;
                result.valid = 1'b1;
                result.value = cap_reg ? mem_rdata : removed_reg;
                result.count = OCW'(cnt_dec);
                result.last  = 1'b1;
            end
            ple_pkg::S_DUMP_SCAN:
            begin
                mem_re     = 1'b1;
                emit_next  = 1'b1;
                elast_next = at_lim;
                if (!at_lim)
                begin
                    idx_next = idx_step;
                end
            end
            ple_pkg::S_DUMP_DRAIN:
            begin
                emit_next = 1'b0;
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase

        // dump beat comes in the cycle after its read
        if (emit_reg)
        begin
            result.valid  = 1'b1;
            result.value  = mem_rdata;
            result.status = ple_pkg::ST_OK;
            result.count  = OCW'(count_reg);
            result.last   = elast_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ple_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            cap_reg   <= 1'b0;
            first_reg <= 1'b0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            cap_reg   <= cap_next;
            first_reg <= first_next;
            emit_reg  <= emit_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        lim_reg     <= lim_next;
        wr_addr_reg <= wr_addr_next;
        elast_reg   <= elast_next;
        val_reg     <= val_next;
        removed_reg <= removed_next;
    end

endmodule

### src/positional_list_engine.sv
// Top level of the positional list engine: sequencer, result register and checks.
//
// Usage: a request (req_type, position, value) is taken at a clock edge where
// start is high and busy is low. Insert places value at position 1..count+1,
// delete removes and returns the entry at position 1..count, dump streams all
// entries in order with last_result on the final beat.
// Every result beat shows on read_value, status, entry_count and last_result
// for exactly one cycle with strobe high; the receiver cannot stall.
// Timing: a rejected request gives its beat in the cycle after acceptance with
// busy staying low. An accepted insert, delete or dump keeps busy high while
// it walks the entries that it moves or reads; the final beat shows in the
// first cycle with busy low again. The walk is bounded by the single read and
// single write port of the entry store, stepped by one shared index counter,
// one entry per cycle.
// Reset clears the entry count and the sequencer; stored words are left as
// they are and are only read below the count.
`include "assert_macros.svh"

module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [ple_pkg::POS_W-1:0]           position,
    input  logic signed [ple_pkg::DATA_W-1:0]   value,
    output logic                                strobe,
    output logic signed [ple_pkg::DATA_W-1:0]   read_value,
    output logic [1:0]                          status,
    output logic [ple_pkg::COUNT_W-1:0]         entry_count,
    output logic                                last_result
);

    ple_pkg::result_t result;

    logic                              strobe_reg;
    logic signed [ple_pkg::DATA_W-1:0] value_reg;
    logic [1:0]                        status_reg;
    logic [ple_pkg::COUNT_W-1:0]       count_reg;
    logic                              last_reg;

    ple_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .position (position),
        .value    (value),
        .busy     (busy),
        .result   (result)
    );

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= result.valid;
        end
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            value_reg  <= result.value;
            status_reg <= result.status;
            count_reg  <= result.count;
            last_reg   <= result.last;
        end
    end

    assign strobe      = strobe_reg;
    assign read_value  = value_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign last_result = last_reg;

    // Checks
    `PLE_ASSERT_SAME(a_count_bound, clk, rst_n, strobe, entry_count <= CAPACITY)
    `PLE_ASSERT_NEXT(a_start_reacts, clk, rst_n, start && !busy, busy || strobe)
    `PLE_ASSERT_SAME(a_error_is_last, clk, rst_n, strobe && (status != ple_pkg::ST_OK),
        last_result && (read_value == '0))
    `PLE_ASSERT_SAME(a_idle_no_beat_pending, clk, rst_n, strobe && !busy, last_result)

endmodule
